>>> rtl/core/jspe_pkg.sv
// shared types, widths and constants of the julia set escape-time core
package jspe_pkg;

    localparam int FRAC_BITS_DEF  = 20;
    localparam int COORD_BITS_DEF = 12;

    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int IN_W       = 12;
    localparam int SIZE_W     = 13;
    localparam int SCALE_W    = 23;
    localparam int CONST_W    = 24;
    localparam int ITER_W     = 11;
    localparam int LIMIT_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RED_W      = 2;
    localparam int GREEN_W    = 7;
    localparam int BLUE_W     = 8;

    localparam logic [RED_W-1:0]   RED_INSIDE   = 2'd3;
    localparam logic [GREEN_W-1:0] GREEN_INSIDE = 7'd78;
    localparam logic [BLUE_W-1:0]  BLUE_INSIDE  = 8'd252;

    localparam logic        [SIZE_W-1:0]  SIZE_RST  = 13'd1080;
    localparam logic        [SCALE_W-1:0] SCALE_RST = 23'd1572864;
    localparam logic signed [CONST_W-1:0] CREAL_RST = -24'sd838861;
    localparam logic signed [CONST_W-1:0] CIMAG_RST = 24'sd163578;
    localparam logic        [ITER_W-1:0]  ITER_RST  = 11'd200;
    localparam logic        [LIMIT_W-1:0] LIMIT_RST = 11'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE     = 3'd0,
        REG_VIEW_SCALE     = 3'd1,
        REG_CONSTANT_REAL  = 3'd2,
        REG_CONSTANT_IMAG  = 3'd3,
        REG_MAX_ITERATIONS = 3'd4,
        REG_ESCAPE_LIMIT   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CPREP,
        ST_CDIV,
        ST_CSTORE,
        ST_IMUL,
        ST_IEVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic coord_mul;
        logic div_load;
        logic div_step;
        logic coord_store;
        logic iter_mul;
        logic iter_eval;
        logic iter_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic coord_row;
        logic escaped;
        logic budget_done;
    } sts_t;

endpackage

>>> rtl/core/jspe_ctrl.sv
// sequencing state machine of the julia set escape-time core
module jspe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    input  jspe_pkg::sts_t sts,
    output jspe_pkg::cmd_t cmd
);
    import jspe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL:
            begin
                cmd.coord_mul = 1'b1;
                state_next    = ST_CPREP;
            end
            ST_CPREP:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_CDIV;
            end
            ST_CDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_CSTORE;
                end
            end
            ST_CSTORE:
            begin
                cmd.coord_store = 1'b1;
                state_next      = sts.coord_row ? ST_IMUL : ST_CMUL;
            end
            ST_IMUL:
            begin
                cmd.iter_mul = 1'b1;
                state_next   = ST_IEVAL;
            end
            ST_IEVAL:
            begin
                cmd.iter_eval = 1'b1;
                if (sts.escaped || sts.budget_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.iter_step = 1'b1;
                    state_next    = ST_IMUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

>>> rtl/core/jspe_dp.sv
// datapath: start point mapping with serial divider and the z*z+c iteration
module jspe_dp #(
    parameter int FRAC_BITS  = jspe_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = jspe_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jspe_pkg::cmd_t                       cmd,
    output jspe_pkg::sts_t                       sts,
    input  logic        [jspe_pkg::IN_W-1:0]     row,
    input  logic        [jspe_pkg::IN_W-1:0]     column,
    input  logic        [jspe_pkg::SIZE_W-1:0]   image_size,
    input  logic        [jspe_pkg::SCALE_W-1:0]  view_scale,
    input  logic signed [jspe_pkg::CONST_W-1:0]  constant_real,
    input  logic signed [jspe_pkg::CONST_W-1:0]  constant_imag,
    input  logic        [jspe_pkg::ITER_W-1:0]   max_iterations,
    input  logic        [jspe_pkg::LIMIT_W-1:0]  escape_limit,
    output logic                                 in_set
);
    import jspe_pkg::*;

    localparam int DIFF_W = (COORD_BITS + 2 > SIZE_W + 1) ? COORD_BITS + 2 : SIZE_W + 1;
    localparam int NUM_W  = SCALE_W + 1 + DIFF_W;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int FX_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W  = FX_W + 2;
    localparam int MAG_W  = FX_W + 1;
    localparam int BND_W  = LIMIT_W + FRAC_BITS;
    localparam int CMP_W  = (MAG_W > BND_W) ? MAG_W : BND_W;

    localparam logic [NUM_W-1:0] QMAX =
        {{(NUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] QMIN_MAG =
        {{(NUM_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] RND  =
        {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-WORD_W:0] hi;
        hi = v[SUM_W-1:WORD_W-1];
        if ((&hi) || !(|hi))
            return v[WORD_W-1:0];
        else
            return v[SUM_W-1] ? WMIN : WMAX;
    endfunction

    // control state
    logic             sel_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             first_reg;
    logic             inside_reg;
    logic [ITER_W-1:0] iter_reg;

    // payload
    logic        [COORD_BITS-1:0] row_reg;
    logic        [COORD_BITS-1:0] col_reg;
    logic signed [NUM_W-1:0]      num_reg;
    logic        [NUM_W-1:0]      dvd_reg;
    logic        [NUM_W-1:0]      dvd_next;
    logic        [SIZE_W-1:0]     rem_reg;
    logic        [SIZE_W-1:0]     rem_next;
    logic                         neg_reg;
    logic signed [WORD_W-1:0]     re_reg;
    logic signed [WORD_W-1:0]     im_reg;
    logic signed [WORD_W-1:0]     re_next;
    logic signed [WORD_W-1:0]     im_next;
    logic signed [PROD_W-1:0]     prr_reg;
    logic signed [PROD_W-1:0]     pii_reg;
    logic signed [PROD_W-1:0]     pri_reg;

    // start point mapping
    logic        [COORD_BITS-1:0] idx;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [SCALE_W:0]      scale_s;
    logic signed [NUM_W-1:0]      num_prod;
    logic        [SIZE_W:0]       rem_sh;
    logic                         q_bit;
    logic signed [WORD_W-1:0]     coord_val;

    // iteration
    logic signed [PROD_W-1:0] pri_adj;
    logic signed [FX_W-1:0]   rr_fx;
    logic signed [FX_W-1:0]   ii_fx;
    logic signed [FX_W-1:0]   ri_fx;
    logic signed [SUM_W-1:0]  nre_w;
    logic signed [SUM_W-1:0]  nim_w;
    logic        [MAG_W-1:0]  mag;
    logic        [BND_W-1:0]  bound;

    assign idx      = sel_reg ? row_reg : col_reg;
    assign diff     = $signed({{(DIFF_W-SIZE_W){1'b0}}, image_size})
                    - $signed({{(DIFF_W-COORD_BITS-1){1'b0}}, idx, 1'b0});
    assign scale_s  = $signed({1'b0, view_scale});
    assign num_prod = NUM_W'(scale_s) * NUM_W'(diff);

    // one restoring quotient bit per cycle
    assign rem_sh   = {rem_reg, dvd_reg[NUM_W-1]};
    assign q_bit    = rem_sh >= {1'b0, image_size};
    assign rem_next = q_bit ? SIZE_W'(rem_sh - {1'b0, image_size}) : rem_sh[SIZE_W-1:0];
    assign dvd_next = {dvd_reg[NUM_W-2:0], q_bit};

    always_comb
    begin
        if (image_size == '0)
            coord_val = '0;
        else if (!neg_reg)
            coord_val = (dvd_reg > QMAX) ? WMAX : $signed(dvd_reg[WORD_W-1:0]);
        else
            coord_val = (dvd_reg > QMIN_MAG) ? WMIN : -$signed(dvd_reg[WORD_W-1:0]);
    end

    // squares are never negative, only the cross term needs truncation toward zero
    assign pri_adj = pri_reg[PROD_W-1] ? pri_reg + RND : pri_reg;
    assign rr_fx   = FX_W'(prr_reg >>> FRAC_BITS);
    assign ii_fx   = FX_W'(pii_reg >>> FRAC_BITS);
    assign ri_fx   = FX_W'(pri_adj >>> FRAC_BITS);
    assign nre_w   = SUM_W'(rr_fx) - SUM_W'(ii_fx) + SUM_W'(constant_real);
    assign nim_w   = (SUM_W'(ri_fx) <<< 1) + SUM_W'(constant_imag);
    assign re_next = sat_word(nre_w);
    assign im_next = sat_word(nim_w);
    assign mag     = MAG_W'($unsigned(rr_fx)) + MAG_W'($unsigned(ii_fx));
    assign bound   = {escape_limit, {FRAC_BITS{1'b0}}};

    assign sts.div_last    = cnt_reg == CNT_W'(NUM_W - 1);
    assign sts.coord_row   = sel_reg;
    assign sts.escaped     = !first_reg && (CMP_W'(mag) > CMP_W'(bound));
    assign sts.budget_done = iter_reg == max_iterations;
    assign in_set          = inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= 1'b0;
            cnt_reg    <= '0;
            first_reg  <= 1'b1;
            inside_reg <= 1'b1;
            iter_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
                sel_reg <= 1'b0;
            else if (cmd.coord_store)
                sel_reg <= !sel_reg;
            if (cmd.div_load)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.coord_store && sel_reg)
            begin
                first_reg <= 1'b1;
                iter_reg  <= '0;
            end
            else if (cmd.iter_step)
            begin
                first_reg <= 1'b0;
                iter_reg  <= iter_reg + ITER_W'(1);
            end
            if (cmd.iter_eval)
                inside_reg <= !sts.escaped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg <= COORD_BITS'(row);
            col_reg <= COORD_BITS'(column);
        end
        if (cmd.coord_mul)
            num_reg <= num_prod;
        if (cmd.div_load)
        begin
            neg_reg <= num_reg[NUM_W-1];
            dvd_reg <= num_reg[NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.coord_store)
        begin
            if (sel_reg)
                im_reg <= coord_val;
            else
                re_reg <= coord_val;
        end
        else if (cmd.iter_step)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
        if (cmd.iter_mul)
        begin
            prr_reg <= PROD_W'(re_reg) * PROD_W'(re_reg);
            pii_reg <= PROD_W'(im_reg) * PROD_W'(im_reg);
            pri_reg <= PROD_W'(re_reg) * PROD_W'(im_reg);
        end
    end

endmodule

>>> rtl/core/julia_set_pixel_escape_core.sv
// top level of the julia set escape-time core: registers, output stage, controller and datapath
//
// One pixel at a time. A transaction on the input channel (row, column) maps the pixel to a
// start point by a multiply and a bit-serial divide per coordinate (one quotient bit per
// cycle), then runs z = z*z + c with a multiply step and an evaluate step per iteration on
// three registered 32x32 multipliers, until escape or budget end.
// The result waits in an output register, and the next pixel is taken while it waits.
// Configuration writes are accepted in every cycle and must be issued while no pixel is in work.
module julia_set_pixel_escape_core #(
    parameter int FRAC_BITS  = jspe_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = jspe_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [jspe_pkg::IN_W-1:0]           row,
    input  logic [jspe_pkg::IN_W-1:0]           column,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                inside_res,
    output logic [jspe_pkg::RED_W-1:0]          red,
    output logic [jspe_pkg::GREEN_W-1:0]        green,
    output logic [jspe_pkg::BLUE_W-1:0]         blue,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jspe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jspe_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jspe_pkg::*;

    logic        [SIZE_W-1:0]  image_size_reg;
    logic        [SCALE_W-1:0] view_scale_reg;
    logic signed [CONST_W-1:0] constant_real_reg;
    logic signed [CONST_W-1:0] constant_imag_reg;
    logic        [ITER_W-1:0]  max_iterations_reg;
    logic        [LIMIT_W-1:0] escape_limit_reg;

    logic               out_valid_reg;
    logic               inside_res_reg;
    logic [RED_W-1:0]   red_reg;
    logic [GREEN_W-1:0] green_reg;
    logic [BLUE_W-1:0]  blue_reg;

    cmd_t cmd;
    sts_t sts;
    logic out_free;
    logic in_set;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg     <= SIZE_RST;
            view_scale_reg     <= SCALE_RST;
            constant_real_reg  <= CREAL_RST;
            constant_imag_reg  <= CIMAG_RST;
            max_iterations_reg <= ITER_RST;
            escape_limit_reg   <= LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_SIZE:     image_size_reg     <= cfg_data[SIZE_W-1:0];
                REG_VIEW_SCALE:     view_scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_CONSTANT_REAL:  constant_real_reg  <= $signed(cfg_data[CONST_W-1:0]);
                REG_CONSTANT_IMAG:  constant_imag_reg  <= $signed(cfg_data[CONST_W-1:0]);
                REG_MAX_ITERATIONS: max_iterations_reg <= cfg_data[ITER_W-1:0];
                REG_ESCAPE_LIMIT:   escape_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            inside_res_reg <= in_set;
            red_reg        <= in_set ? RED_INSIDE : '0;
            green_reg      <= in_set ? GREEN_INSIDE : '0;
            blue_reg       <= in_set ? BLUE_INSIDE : '0;
        end
    end

    jspe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    jspe_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .row            (row),
        .column         (column),
        .image_size     (image_size_reg),
        .view_scale     (view_scale_reg),
        .constant_real  (constant_real_reg),
        .constant_imag  (constant_imag_reg),
        .max_iterations (max_iterations_reg),
        .escape_limit   (escape_limit_reg),
        .in_set         (in_set)
    );

endmodule

>>> sim/tb_julia_set_pixel_escape_core.sv
// self-checking testbench for the julia set escape-time core with a fixed-point color predictor
module tb_julia_set_pixel_escape_core;

    timeunit 1ns;
    timeprecision 1ps;

    import jspe_pkg::*;

    localparam int     FRAC         = FRAC_BITS_DEF;
    localparam longint WORD_HI      = 64'sd2147483647;
    localparam longint WORD_LO      = -64'sd2147483648;
    localparam int     RESET_CYCLES = 12;
    localparam int     CYCLE_LIMIT  = 4000000;
    localparam int     TAIL_CYCLES  = 500;
    localparam int     HOLD_CYCLES  = 3000;
    localparam int     PHASES       = 16;
    localparam int     PHASE_PIXELS = 125;
    localparam int     HOLD_PHASE   = 4;

    typedef struct packed {
        logic               in_set;
        logic [RED_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic [BLUE_W-1:0]  blue;
    } pixel_color_t;

    typedef struct packed {
        logic [IN_W-1:0] row;
        logic [IN_W-1:0] column;
        pixel_color_t    color;
    } awaited_pixel_t;

    class escape_color_scoreboard;
        int             img_size;
        int             half_width;
        longint         c_re;
        longint         c_im;
        int             iter_budget;
        int             bound_whole;
        int             mismatches;
        awaited_pixel_t awaited[$];

        function new();
            img_size    = int'(SIZE_RST);
            half_width  = int'(SCALE_RST);
            c_re        = longint'(CREAL_RST);
            c_im        = longint'(CIMAG_RST);
            iter_budget = int'(ITER_RST);
            bound_whole = int'(LIMIT_RST);
            mismatches  = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_SIZE:     img_size    = int'(data[SIZE_W-1:0]);
                REG_VIEW_SCALE:     half_width  = int'(data[SCALE_W-1:0]);
                REG_CONSTANT_REAL:  c_re        = longint'($signed(data[CONST_W-1:0]));
                REG_CONSTANT_IMAG:  c_im        = longint'($signed(data[CONST_W-1:0]));
                REG_MAX_ITERATIONS: iter_budget = int'(data[ITER_W-1:0]);
                REG_ESCAPE_LIMIT:   bound_whole = int'(data[LIMIT_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_HI)
                return WORD_HI;
            if (v < WORD_LO)
                return WORD_LO;
            return v;
        endfunction

        // product truncated toward zero
        function longint fixed_mul(longint a, longint b);
            longint p;
            p = a * b;
            if (p < 0)
                return -((-p) >>> FRAC);
            return p >>> FRAC;
        endfunction

        function longint start_point(int idx);
            longint num;
            if (img_size == 0)
                return 0;
            num = longint'(half_width) * (longint'(img_size) - 2 * longint'(idx));
            return clamp_word(num / longint'(img_size));
        endfunction

        function pixel_color_t escape_color_of(logic [IN_W-1:0] row, logic [IN_W-1:0] column);
            longint       re;
            longint       im;
            longint       nre;
            longint       nim;
            longint       bound;
            bit           in_set;
            int           n;
            pixel_color_t color;
            re     = start_point(int'(column));
            im     = start_point(int'(row));
            bound  = longint'(bound_whole) <<< FRAC;
            in_set = 1'b1;
            for (n = 0; n < iter_budget && in_set; n++)
            begin
                nre = clamp_word(fixed_mul(re, re) - fixed_mul(im, im) + c_re);
                nim = clamp_word(2 * fixed_mul(re, im) + c_im);
                re  = nre;
                im  = nim;
                if (fixed_mul(re, re) + fixed_mul(im, im) > bound)
                    in_set = 1'b0;
            end
            color = '0;
            if (in_set)
                color = '{1'b1, RED_INSIDE, GREEN_INSIDE, BLUE_INSIDE};
            return color;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("ERROR: %s", what);
        endtask

        function void note_pixel(logic [IN_W-1:0] row, logic [IN_W-1:0] column);
            awaited.push_back('{row, column, escape_color_of(row, column)});
        endfunction

        task check_pixel(pixel_color_t got);
            awaited_pixel_t w;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with no pixel in flight, inside_res=%0b", got.in_set));
                return;
            end
            w = awaited.pop_front();
            if (got.in_set !== w.color.in_set)
                report($sformatf("pixel (%0d,%0d) inside_res got %0b want %0b",
                                 w.row, w.column, got.in_set, w.color.in_set));
            if (got.red !== w.color.red)
                report($sformatf("pixel (%0d,%0d) red got %0d want %0d",
                                 w.row, w.column, got.red, w.color.red));
            if (got.green !== w.color.green)
                report($sformatf("pixel (%0d,%0d) green got %0d want %0d",
                                 w.row, w.column, got.green, w.color.green));
            if (got.blue !== w.color.blue)
                report($sformatf("pixel (%0d,%0d) blue got %0d want %0d",
                                 w.row, w.column, got.blue, w.color.blue));
        endtask

        function int pending();
            return awaited.size();
        endfunction

        task wrap_up(output bit clean);
            if (awaited.size() != 0)
                report($sformatf("%0d pixels never produced a result", awaited.size()));
            clean = (mismatches == 0);
        endtask
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [IN_W-1:0]       row        = '0;
    logic [IN_W-1:0]       column     = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  inside_res;
    logic [RED_W-1:0]      red;
    logic [GREEN_W-1:0]    green;
    logic [BLUE_W-1:0]     blue;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_IMAGE_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int                     cycle_count     = 0;
    int                     sender_idle_pct = 0;
    int                     stall_pct       = 0;
    int                     hold_left       = 0;
    escape_color_scoreboard ledger;

    julia_set_pixel_escape_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .row        (row),
        .column     (column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                ledger.set_register(cfg_idx_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                ledger.note_pixel(row, column);
            if (out_valid && out_ready)
                ledger.check_pixel({inside_res, red, green, blue});
        end
    end

    task automatic send_pixel(input logic [IN_W-1:0] r, input logic [IN_W-1:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        row      <= r;
        column   <= c;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_DATA_W-1:0] size,
                                 input logic [CFG_DATA_W-1:0] scale,
                                 input logic [CFG_DATA_W-1:0] cre,
                                 input logic [CFG_DATA_W-1:0] cim,
                                 input logic [CFG_DATA_W-1:0] iters,
                                 input logic [CFG_DATA_W-1:0] lim);
        cfg_idx_t              order [6];
        logic [CFG_DATA_W-1:0] vals  [6];
        order = '{REG_IMAGE_SIZE, REG_VIEW_SCALE, REG_CONSTANT_REAL,
                  REG_CONSTANT_IMAG, REG_MAX_ITERATIONS, REG_ESCAPE_LIMIT};
        vals  = '{size, scale, cre, cim, iters, lim};
        for (int k = 0; k < 6; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_setting(output int span);
        logic [CFG_DATA_W-1:0] size;
        logic [CFG_DATA_W-1:0] scale;
        logic [CFG_DATA_W-1:0] cre;
        logic [CFG_DATA_W-1:0] cim;
        logic [CFG_DATA_W-1:0] iters;
        logic [CFG_DATA_W-1:0] lim;
        if ($urandom_range(99) < 25)
        begin
            size  = CFG_DATA_W'($urandom_range(0, 8191));
            scale = CFG_DATA_W'($urandom_range(0, 8388607));
            cre   = 24'($urandom);
            cim   = 24'($urandom);
            iters = CFG_DATA_W'($urandom_range(0, 64));
            lim   = CFG_DATA_W'($urandom_range(0, 2047));
        end
        else
        begin
            size  = $urandom_range(1) ? CFG_DATA_W'($urandom_range(2, 64))
                                      : CFG_DATA_W'($urandom_range(2, 4096));
            scale = CFG_DATA_W'($urandom_range(786432, 2097152));
            cre   = 24'($urandom_range(0, 2097152)) - 24'd1048576;
            cim   = 24'($urandom_range(0, 2097152)) - 24'd1048576;
            iters = CFG_DATA_W'($urandom_range(1, 48));
            lim   = CFG_DATA_W'($urandom_range(1, 1024));
        end
        write_setting(size, scale, cre, cim, iters, lim);
        span = (size == 0 || size > 4096) ? 4096 : int'(size);
    endtask

    task automatic random_pixels(input int span, input int count);
        logic [IN_W-1:0] r;
        logic [IN_W-1:0] c;
        repeat (count)
        begin
            if ($urandom_range(99) < 85)
            begin
                r = IN_W'($urandom_range(span - 1));
                c = IN_W'($urandom_range(span - 1));
            end
            else
            begin
                r = IN_W'($urandom);
                c = IN_W'($urandom);
            end
            send_pixel(r, c);
        end
    endtask

    initial
    begin
        int span;
        bit clean;
        ledger = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-on setting
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd540, 12'd540);
        send_pixel(12'd1079, 12'd1079);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);

        // tiny image, widest view and constants, start points saturate for the far rows and columns
        settle_idle();
        write_setting(24'd2, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd3, 24'd2047);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd2048, 12'd1);

        // zero image size with zero limit, orbit stays at the origin
        settle_idle();
        write_setting(24'd0, 24'd4194304, 24'd0, 24'd0, 24'd5, 24'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // largest image, smallest nonzero scale, zero limit escapes on any nonzero magnitude
        settle_idle();
        write_setting(24'd8191, 24'd1, 24'd1024, -24'sd1024, 24'd4, 24'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd4095);

        // zero iteration budget
        settle_idle();
        write_setting(24'(SIZE_RST), 24'(SCALE_RST), 24'(CREAL_RST), 24'(CIMAG_RST),
                      24'd0, 24'd1000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // largest iteration budget
        settle_idle();
        write_setting(24'(SIZE_RST), 24'(SCALE_RST), 24'(CREAL_RST), 24'(CIMAG_RST),
                      24'd2047, 24'd1024);
        send_pixel(12'd540, 12'd540);
        send_pixel(12'd300, 12'd700);
        send_pixel(12'd0, 12'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            write_random_setting(span);
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 77;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 77;
                end
                default:
                begin
                    sender_idle_pct = 11;
                    stall_pct       = 11;
                end
            endcase
            if (p == HOLD_PHASE)
                hold_left <= HOLD_CYCLES;
            random_pixels(span, PHASE_PIXELS);
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        ledger.wrap_up(clean);
        if (clean)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/jspe_pkg.sv
rtl/core/jspe_ctrl.sv
rtl/core/jspe_dp.sv
rtl/core/julia_set_pixel_escape_core.sv
sim/tb_julia_set_pixel_escape_core.sv
